### hdl/bda_pkg.sv
// bda_pkg: types and constants shared by the button debounce and auto-repeat block
// used by bda_update and button_debounce_auto_repeat, no dependencies

package bda_pkg;

	// counter wraps to zero above this value
	localparam logic [7:0] COUNT_WRAP = 8'd170;
	// release fires when the count lies in [SHORT_LOW, SHORT_HIGH)
	localparam logic [7:0] SHORT_LOW  = 8'd2;
	localparam logic [7:0] SHORT_HIGH = 8'd14;

	// width of a zero-extended slot number, enough to compare against 64 slots
	localparam int SLOT_EXT_W = 7;

	typedef enum logic [1:0] {
		THR_NORMAL = 2'd0,
		THR_HOLD   = 2'd1,
		THR_REPEAT = 2'd2
	} thr_sel_t;

	typedef enum logic [3:0] {
		REG_NORMAL_DELAY    = 4'd0,
		REG_HOLD_DELAY      = 4'd1,
		REG_REPEAT_INTERVAL = 4'd2,
		REG_REPEAT_MASK     = 4'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] press_count;
		thr_sel_t   thr_sel;
		logic       latched;
		logic       held;
	} slot_state_t;

	typedef struct packed {
		logic [7:0] normal_delay;
		logic [7:0] hold_delay;
		logic [7:0] repeat_interval;
	} delay_cfg_t;

endpackage

### hdl/bda_update.sv
// bda_update: next-state and fire decision for one button slot on one sample
// depends on bda_pkg

module bda_update import bda_pkg::*; (
	input  slot_state_t cur,
	input  logic        pressed,
	input  logic        is_repeat,
	input  delay_cfg_t  delays,
	output slot_state_t nxt,
	output logic        fire
);

	logic [7:0] thr;
	logic [7:0] cnt;
	thr_sel_t   sel;
	logic       latched;
	logic       held;

	always_comb begin
		case (cur.thr_sel)
			THR_HOLD:   thr = delays.hold_delay;
			THR_REPEAT: thr = delays.repeat_interval;
			default:    thr = delays.normal_delay;
		endcase
	end

	always_comb begin
		cnt     = cur.press_count;
		sel     = cur.thr_sel;
		latched = cur.latched;
		held    = cur.held;
		fire    = 1'b0;
		if (pressed) begin
			cnt = cnt + 8'd1;
			if (cnt == thr) begin
				if (!is_repeat) begin
					if (!latched) begin
						latched = 1'b1;
						fire    = 1'b1;
					end
				end else if (held) begin
					fire = 1'b1;
					sel  = THR_REPEAT;
				end else begin
					sel = THR_HOLD;
				end
				cnt  = 8'd0;
				held = 1'b1;
			end
			if (cnt > COUNT_WRAP) begin
				cnt = 8'd0;
			end
		end else begin
			// release of a latched one-shot clears the slot before the short-press check
			if (latched) begin
				cnt     = 8'd0;
				latched = 1'b0;
				held    = 1'b0;
			end
			if (held) begin
				if (cnt >= SHORT_LOW && cnt < SHORT_HIGH) begin
					fire = 1'b1;
				end
				cnt  = 8'd0;
				held = 1'b0;
				sel  = THR_NORMAL;
			end
		end
		nxt.press_count = cnt;
		nxt.thr_sel     = sel;
		nxt.latched     = latched;
		nxt.held        = held;
	end

endmodule

### hdl/button_debounce_auto_repeat.sv
// button_debounce_auto_repeat: top level, per-slot state memory, pipeline and config registers
// depends on bda_pkg and bda_update
//
// Usage:
// - sample channel (sample_valid, sample_stall, button_slot, level_pressed) carries one
//   debounce sample per transaction for the button slot it names
// - result channel (result_valid, result_stall, fire) returns exactly one transaction per
//   sample, in order; fire is high when that sample triggers a button action
// - config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the delay registers
//   and the repeat mask; cfg_ready is always high, unknown indexes are dropped; write only
//   while no sample is in flight
// - pipeline: the slot state is read into the sample stage when a sample is accepted; the
//   update runs from that stage and its outcome is loaded into the result register
// - throughput: one sample per cycle while the result channel does not stall, also back to
//   back on the same slot, since the slot state written by one sample is forwarded into the read of the next
// - a stalled result register holds its value; the sample stage then stalls, and the
//   sample channel stalls once that stage is also full
// - reset clears the pipeline, the per-slot valid bits (every slot reads as idle state)
//   and loads the register defaults 10, 60, 15 and an all one-shot mask

module button_debounce_auto_repeat import bda_pkg::*; #(
	parameter int BUTTON_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [3:0]  button_slot,
	input  logic        level_pressed,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        fire,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = (BUTTON_SLOTS > 1) ? $clog2(BUTTON_SLOTS) : 1;

	// configuration registers
	delay_cfg_t  delays_q;
	logic [15:0] repeat_mask_q;

	// slot state memory and its valid bits
	slot_state_t             state_mem [BUTTON_SLOTS];
	logic [BUTTON_SLOTS-1:0] state_vld_q;

	// sample stage
	logic        s1_valid_q;
	logic [3:0]  slot_s1;
	logic        pressed_s1;
	logic        in_range_s1;
	slot_state_t entry_s1;
	logic        entry_vld_s1;

	// result register
	logic res_valid_q;
	logic fire_q;

	logic [SLOT_EXT_W-1:0] in_slot_ext;
	logic [SLOT_EXT_W-1:0] s1_slot_ext;
	logic [AW-1:0]         in_addr;
	logic [AW-1:0]         wr_addr;
	logic                  in_range;
	logic                  accept;
	logic                  res_ready;
	logic                  s1_adv;
	logic                  wr_en;
	logic                  fwd_hit;
	slot_state_t           cur;
	slot_state_t           nxt;
	logic                  upd_fire;

	assign cfg_ready = 1'b1;

	assign in_slot_ext = {{(SLOT_EXT_W-4){1'b0}}, button_slot};
	assign s1_slot_ext = {{(SLOT_EXT_W-4){1'b0}}, slot_s1};
	assign in_addr     = in_slot_ext[AW-1:0];
	assign wr_addr     = s1_slot_ext[AW-1:0];
	assign in_range    = in_slot_ext < SLOT_EXT_W'(BUTTON_SLOTS);

	assign res_ready    = !res_valid_q || !result_stall;
	assign s1_adv       = s1_valid_q && res_ready;
	assign sample_stall = s1_valid_q && !res_ready;
	assign accept       = sample_valid && !sample_stall;

	assign wr_en   = s1_adv && in_range_s1;
	assign fwd_hit = wr_en && (wr_addr == in_addr);
	assign cur     = entry_vld_s1 ? entry_s1 : '0;

	bda_update u_update (
		.cur       (cur),
		.pressed   (pressed_s1),
		.is_repeat (repeat_mask_q[slot_s1]),
		.delays    (delays_q),
		.nxt       (nxt),
		.fire      (upd_fire)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delays_q.normal_delay    <= 8'd10;
			delays_q.hold_delay      <= 8'd60;
			delays_q.repeat_interval <= 8'd15;
			repeat_mask_q            <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_NORMAL_DELAY:    delays_q.normal_delay    <= cfg_data[7:0];
				REG_HOLD_DELAY:      delays_q.hold_delay      <= cfg_data[7:0];
				REG_REPEAT_INTERVAL: delays_q.repeat_interval <= cfg_data[7:0];
				REG_REPEAT_MASK:     repeat_mask_q            <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			state_mem[wr_addr] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_vld_q <= '0;
		end else if (wr_en) begin
			state_vld_q[wr_addr] <= 1'b1;
		end
	end

	// read at accept, taking the value being written this edge for the same slot
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_s1     <= button_slot;
			pressed_s1  <= level_pressed;
			in_range_s1 <= in_range;
			if (fwd_hit) begin
				entry_s1     <= nxt;
				entry_vld_s1 <= 1'b1;
			end else begin
				entry_s1     <= state_mem[in_addr];
				entry_vld_s1 <= in_range && state_vld_q[in_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!sample_stall) begin
			s1_valid_q <= sample_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_ready) begin
			res_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			fire_q <= in_range_s1 && upd_fire;
		end
	end

	assign result_valid = res_valid_q;
	assign fire         = fire_q;

	// the sample channel only stalls behind a full, blocked sample stage
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (s1_valid_q && res_valid_q && result_stall))
		else $error("sample stall without a blocked pipeline");

	// a stored count never exceeds the wrap value
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (nxt.press_count <= COUNT_WRAP))
		else $error("press count stored above wrap value");

	// a release on an idle slot never fires
	a_idle_release_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && !pressed_s1 && !cur.held && !cur.latched) |=> !fire_q)
		else $error("fire on release of an idle slot");

endmodule
